@@ rtl/cfrv_pkg.sv @@
// shared types, constants and helper functions for the framed record verifier
package cfrv_pkg;

    localparam int unsigned POS_W     = 21;
    localparam int unsigned HDR_BYTES = 16;
    localparam logic [POS_W-1:0] POS_SAT   = 21'h1F_FFFF;
    localparam logic [POS_W-1:0] CAP_RESET = 21'd1048576;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRUPT   = 2'd1,
        ST_TOO_SMALL = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    // one classified beat from the front: a payload byte, a status, or both
    typedef struct packed {
        logic             has_payload;
        logic [7:0]       data;
        logic             has_status;
        status_t          status;
        logic [POS_W-1:0] length;
    } entry_t;

    // expected bytes of the fixed header part: magic word, version, header size
    function automatic logic [7:0] hdr_expect(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h41;
            3'd1:    val = 8'h43;
            3'd2:    val = 8'h47;
            3'd3:    val = 8'h53;
            3'd4:    val = 8'h01;
            3'd5:    val = 8'h00;
            3'd6:    val = 8'h10;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // reflected crc-32 over one byte, unrolled to an xor network
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

@@ rtl/cfrv_front.sv @@
// front part: accepts record bytes, checks the header, runs the crc and decides status
module cfrv_front #(
    parameter int unsigned MAX_PAYLOAD = 1048576
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [20:0]            capacity_limit,
    input  logic                   q_full,
    output logic                   q_push,
    output cfrv_pkg::entry_t       q_entry
);
    import cfrv_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_good_reg, hdr_good_next;
    logic [31:0]      decl_reg, decl_next;
    logic [31:0]      chk_reg, chk_next;
    logic [31:0]      crc_reg, crc_next;
    logic [POS_W-1:0] cap_reg;

    logic             accept;
    logic             is_payload;
    logic             sat_hit;
    logic             corrupt;
    status_t          status_val;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= capacity_limit;
    end

    // header capture, crc and byte count for this beat
    always_comb
    begin
        is_payload    = pos_reg >= POS_W'(HDR_BYTES);
        sat_hit       = pos_reg == POS_SAT;
        pos_next      = sat_hit ? pos_reg : pos_reg + 1'b1;
        hdr_good_next = hdr_good_reg;
        decl_next     = decl_reg;
        chk_next      = chk_reg;
        crc_next      = is_payload ? crc_byte(crc_reg, data_byte) : crc_reg;
        if (!is_payload)
        begin
            if (pos_reg[3] == 1'b0)
            begin
                if (data_byte != hdr_expect(pos_reg[2:0]))
                    hdr_good_next = 1'b0;
            end
            else if (pos_reg[2] == 1'b0)
            begin
                decl_next[8*pos_reg[1:0] +: 8] = decl_reg[8*pos_reg[1:0] +: 8] | data_byte;
            end
            else
            begin
                chk_next[8*pos_reg[1:0] +: 8] = chk_reg[8*pos_reg[1:0] +: 8] | data_byte;
            end
        end
    end

    // status decision on the final byte
    always_comb
    begin
        corrupt = (pos_next < POS_W'(HDR_BYTES)) || sat_hit || !hdr_good_next
                  || (decl_next > 32'(MAX_PAYLOAD))
                  || (({1'b0, decl_next} + 33'(HDR_BYTES)) != {12'd0, pos_next});
        if (corrupt)
            status_val = ST_CORRUPT;
        else if (decl_next > {11'd0, cap_reg})
            status_val = ST_TOO_SMALL;
        else if ((crc_next ^ CRC_ONES) != chk_next)
            status_val = ST_CORRUPT;
        else
            status_val = ST_OK;
    end

    // beat toward the back part
    always_comb
    begin
        q_push              = accept && (is_payload || last_byte);
        q_entry.has_payload = is_payload;
        q_entry.data        = data_byte;
        q_entry.has_status  = last_byte;
        q_entry.status      = status_val;
        q_entry.length      = (status_val == ST_OK) ? decl_next[POS_W-1:0] : '0;
    end

    // record state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_good_reg <= 1'b1;
            decl_reg     <= '0;
            chk_reg      <= '0;
            crc_reg      <= CRC_ONES;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg      <= '0;
                hdr_good_reg <= 1'b1;
                decl_reg     <= '0;
                chk_reg      <= '0;
                crc_reg      <= CRC_ONES;
            end
            else
            begin
                pos_reg      <= pos_next;
                hdr_good_reg <= hdr_good_next;
                decl_reg     <= decl_next;
                chk_reg      <= chk_next;
                crc_reg      <= crc_next;
            end
        end
    end

endmodule

@@ rtl/cfrv_queue.sv @@
// short queue of classified beats between front and back
module cfrv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  cfrv_pkg::entry_t  wr_entry,
    input  logic              rd_en,
    output cfrv_pkg::entry_t  rd_entry,
    output logic              q_full,
    output logic              q_empty
);
    import cfrv_pkg::*;

    entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full   = cnt_reg == QCNT_W'(QDEPTH);
    assign q_empty  = cnt_reg == '0;
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_entry = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_entry;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ rtl/cfrv_back.sv @@
// back part: expands queued beats into results and holds the output register
module cfrv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cfrv_pkg::entry_t  head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic              result_kind,
    output logic [7:0]        payload_byte,
    output logic [1:0]        status,
    output logic [20:0]       verified_length,
    output logic              end_of_run
);
    import cfrv_pkg::*;

    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    status_t          status_reg, status_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic             end_reg, end_next;
    logic             phase_reg, phase_next;
    logic             load_ok;
    logic             take;
    logic             emit_status;

    assign empty           = !out_valid_reg;
    assign result_kind     = kind_reg;
    assign payload_byte    = byte_reg;
    assign status          = status_reg;
    assign verified_length = len_reg;
    assign end_of_run      = end_reg;

    // pick the next result from the queue head
    always_comb
    begin
        load_ok        = !out_valid_reg || pop;
        take           = load_ok && !q_empty;
        emit_status    = phase_reg || !head.has_payload;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        len_next       = len_reg;
        end_next       = end_reg;
        phase_next     = phase_reg;
        q_pop          = 1'b0;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (emit_status)
            begin
                kind_next   = KIND_STATUS;
                byte_next   = '0;
                status_next = head.status;
                len_next    = head.length;
                end_next    = 1'b1;
                phase_next  = 1'b0;
                q_pop       = 1'b1;
            end
            else
            begin
                kind_next   = KIND_PAYLOAD;
                byte_next   = head.data;
                status_next = ST_OK;
                len_next    = '0;
                end_next    = !head.has_status;
                phase_next  = head.has_status;
                q_pop       = !head.has_status;
            end
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        len_reg    <= len_next;
        end_reg    <= end_next;
    end

endmodule

@@ rtl/crc_framed_record_verifier.sv @@
// top level of the framed record verifier: front, beat queue and back
// a beat passes through the beat queue and then the output register before it shows as a result
// throughput: one byte per cycle while the queue is not full; a final payload byte
//   yields two results, the byte and then the status, from the single output register
// reset: asynchronous, clears record state, queue and output; capacity returns
//   to 1048576; no clearing pass is needed
module crc_framed_record_verifier #(
    parameter int unsigned MAX_PAYLOAD = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] capacity_limit,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  status,
    output logic [20:0] verified_length,
    output logic        end_of_run
);
    import cfrv_pkg::*;

    entry_t f_entry;
    entry_t q_head;
    logic   f_push;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    // front part
    cfrv_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_limit (capacity_limit),
        .q_full         (q_full),
        .q_push         (f_push),
        .q_entry        (f_entry)
    );

    // beat queue
    cfrv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_push),
        .wr_entry (f_entry),
        .rd_en    (q_pop),
        .rd_entry (q_head),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    // back part
    cfrv_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .result_kind     (result_kind),
        .payload_byte    (payload_byte),
        .status          (status),
        .verified_length (verified_length),
        .end_of_run      (end_of_run)
    );

    // a status result always closes the run
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_STATUS) |-> end_of_run)
        else $error("status result without end of run");

    // payload results carry no status or length
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_PAYLOAD) |-> (status == ST_OK && verified_length == '0))
        else $error("payload result with status or length");

    // a failing status reports zero length
    a_fail_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_STATUS && status != ST_OK) |-> verified_length == '0)
        else $error("failing status with nonzero length");

    // queue never pops while empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("queue pop while empty");

endmodule
